/* rtl/lpp_pkg.sv */
// Shared types and constants for the line position PID block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package lpp_pkg;

  localparam int unsigned LPP_ARRAY_COUNT = 8;

  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned THR_W    = 18;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned EFFORT_W = 13;
  localparam int unsigned ERR_W    = 9;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_REF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]  LINE_REF_RST = 8'd100;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 8'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 12'd1000;

  // Position weights and the lost-line feedback extreme.
  localparam int unsigned WEIGHT_MID = 100;
  localparam logic [7:0]  FB_MAX     = 8'd200;

  // Shared divider: remainder width and quotient bits per division.
  localparam int unsigned DIV_W      = 25;
  localparam int unsigned QUO_W      = 11;
  localparam int unsigned FB_STEPS   = 8;
  localparam int unsigned GAIN_STEPS = 11;
  localparam int unsigned CNT_W      = 4;

  // Gain term selector.
  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_I = 2'd1;
  localparam logic [1:0] GAIN_D = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       set_err;
    logic       gain_load;
    logic [1:0] gain_sel;
    logic       gain_acc;
    logic       finish;
  } lpp_cmd_t;

  typedef struct packed {
    logic out_free;
  } lpp_status_t;

endpackage

/* rtl/lpp_if.sv */
// Valid/ready channel interfaces of the line position PID block: input items,
// result items and configuration writes. Depends on lpp_pkg.
interface lpp_in_if import lpp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    array_index;
  logic [PERIOD_W-1:0] left_period;
  logic [PERIOD_W-1:0] middle_period;
  logic [PERIOD_W-1:0] right_period;
  logic [THR_W-1:0]    lost_threshold;

  modport source (output valid, array_index, left_period, middle_period, right_period,
                  lost_threshold, input ready);
  modport sink (input valid, array_index, left_period, middle_period, right_period,
                lost_threshold, output ready);
endinterface

interface lpp_out_if import lpp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [EFFORT_W-1:0] control_effort;
  logic signed [ERR_W-1:0]    position_error;
  logic                       line_lost;

  modport source (output valid, control_effort, position_error, line_lost, input ready);
  modport sink (input valid, control_effort, position_error, line_lost, output ready);
endinterface

interface lpp_cfg_if import lpp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/lpp_ctrl.sv */
// Sequencer of the line position PID block: steps the shared divider through
// the position division and the three gain divisions. Depends on lpp_pkg.
module lpp_ctrl import lpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lpp_status_t status_i,
  output lpp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FB    = 3'd1;
  localparam logic [2:0] S_ERR   = 3'd2;
  localparam logic [2:0] S_GLOAD = 3'd3;
  localparam logic [2:0] S_GDIV  = 3'd4;
  localparam logic [2:0] S_GACC  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       op_q, op_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_FB;
        end
      end
      S_FB: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(FB_STEPS - 1)) begin
          state_d = S_ERR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ERR: begin
        cmd_o.set_err = 1'b1;
        state_d       = S_GLOAD;
      end
      S_GLOAD: begin
        cmd_o.gain_load = 1'b1;
        cmd_o.gain_sel  = GAIN_P;
        op_d            = GAIN_P;
        cnt_d           = '0;
        state_d         = S_GDIV;
      end
      S_GDIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(GAIN_STEPS - 1)) begin
          state_d = S_GACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_GACC: begin
        // The finished term is added while the next term's division is set up.
        cmd_o.gain_acc = 1'b1;
        if (op_q == GAIN_D) begin
          state_d = S_FIN;
        end else begin
          cmd_o.gain_load = 1'b1;
          cmd_o.gain_sel  = op_q + 1'b1;
          op_d            = op_q + 1'b1;
          cnt_d           = '0;
          state_d         = S_GDIV;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      op_q    <= GAIN_P;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

endmodule

/* rtl/lpp_datapath.sv */
// Datapath of the line position PID block: configuration registers, per-array
// error and effort history, the shared restoring divider and the result register.
// Depends on lpp_pkg.
module lpp_datapath import lpp_pkg::*; #(
  parameter int unsigned ARRAY_COUNT = LPP_ARRAY_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpp_cmd_t                   cmd_i,
  output lpp_status_t                status_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [IDX_W-1:0]           array_index_i,
  input  logic [PERIOD_W-1:0]        left_period_i,
  input  logic [PERIOD_W-1:0]        middle_period_i,
  input  logic [PERIOD_W-1:0]        right_period_i,
  input  logic [THR_W-1:0]           lost_threshold_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [EFFORT_W-1:0] control_effort_o,
  output logic signed [ERR_W-1:0]    position_error_o,
  output logic                       line_lost_o
);

  localparam int unsigned AW = (ARRAY_COUNT > 1) ? $clog2(ARRAY_COUNT) : 1;

  // Configuration registers.
  logic [GAIN_W-1:0]  ref_q, kp_q, ki_q, kd_q;
  logic [LIMIT_W-1:0] limit_q;

  // Per-array history. The oldest error of an item is the middle one before
  // the shift, so only the two newest errors need storage.
  logic signed [ERR_W-1:0]    hist_new_q [ARRAY_COUNT];
  logic signed [ERR_W-1:0]    hist_mid_q [ARRAY_COUNT];
  logic signed [EFFORT_W-1:0] prev_eff_q [ARRAY_COUNT];

  // Item registers.
  logic [AW-1:0]              idx_q;
  logic                       sum_zero_q;
  logic                       lost_q;
  logic signed [ERR_W-1:0]    e0_q;
  logic signed [EFFORT_W-1:0] acc_q;
  logic                       sign_q;

  // Divider registers.
  logic [DIV_W-1:0] rem_q, dreg_q;
  logic [QUO_W-1:0] quo_q;

  // Result register.
  logic                       out_valid_q;
  logic signed [EFFORT_W-1:0] effort_q;
  logic signed [ERR_W-1:0]    perr_q;
  logic                       olost_q;

  // Input stage: array index wrap, period sum and weighted numerator.
  logic [3:0]      idx_m;
  logic [THR_W-1:0] sum_w;
  logic [THR_W-1:0] wsum_w;
  logic [DIV_W-1:0] num_w;

  always_comb begin
    idx_m = {1'b0, array_index_i};
    for (int k = 0; k < 8; k++) begin
      if (idx_m >= ARRAY_COUNT) begin
        idx_m = idx_m - 4'(ARRAY_COUNT);
      end
    end
    sum_w  = THR_W'(left_period_i) + THR_W'(middle_period_i) + THR_W'(right_period_i);
    wsum_w = THR_W'(middle_period_i) + {1'b0, right_period_i, 1'b0};
    num_w  = DIV_W'(wsum_w) * DIV_W'(WEIGHT_MID);
  end

  // Current history of the selected array.
  logic signed [ERR_W-1:0]    e1_w, e2_w;
  logic signed [EFFORT_W-1:0] pu_w;
  assign e1_w = hist_new_q[idx_q];
  assign e2_w = hist_mid_q[idx_q];
  assign pu_w = prev_eff_q[idx_q];

  // Error from the quotient, with the lost-line override.
  logic [7:0]              fb_w;
  logic signed [ERR_W-1:0] e0_w;

  always_comb begin
    fb_w = sum_zero_q ? 8'd0 : quo_q[7:0];
    if (lost_q) begin
      if (e1_w < 0) begin
        fb_w = 8'd0;
      end else if (e1_w > 0) begin
        fb_w = FB_MAX;
      end
    end
    e0_w = ERR_W'($signed({2'b00, fb_w}) - $signed({2'b00, ref_q}));
  end

  // Gain term numerator and divisor.
  logic signed [11:0] e0x, e1x, e2x, gnum_w;
  logic [11:0]        gmag_w;
  logic [GAIN_W-1:0]  gden_w;

  always_comb begin
    e0x = 12'(e0_q);
    e1x = 12'(e1_w);
    e2x = 12'(e2_w);
    unique case (cmd_i.gain_sel)
      GAIN_P: begin
        gnum_w = e0x;
        gden_w = kp_q;
      end
      GAIN_I: begin
        gnum_w = e0x - e1x;
        gden_w = ki_q;
      end
      GAIN_D: begin
        gnum_w = 12'((e0x + e2x - (e1x <<< 1)) <<< 1);
        gden_w = kd_q;
      end
      default: begin
        gnum_w = e0x;
        gden_w = kp_q;
      end
    endcase
    if (gden_w == '0) begin
      gden_w = GAIN_RST;
    end
    gmag_w = gnum_w[11] ? 12'(-gnum_w) : 12'(gnum_w);
  end

  // Signed quotient of the finished gain term.
  logic signed [EFFORT_W-1:0] term_w;
  assign term_w = sign_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  // Clamp against the previous effort of this array.
  logic [EFFORT_W-1:0]        pmag_w;
  logic signed [EFFORT_W-1:0] effort_w;

  always_comb begin
    pmag_w   = pu_w[EFFORT_W-1] ? EFFORT_W'(-pu_w) : EFFORT_W'(pu_w);
    effort_w = acc_q;
    if (pmag_w >= {1'b0, limit_q}) begin
      if (pu_w > 0) begin
        effort_w = $signed({1'b0, limit_q});
      end else if (pu_w < 0) begin
        effort_w = -$signed({1'b0, limit_q});
      end else begin
        effort_w = '0;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= LINE_REF_RST;
      kp_q    <= GAIN_RST;
      ki_q    <= GAIN_RST;
      kd_q    <= GAIN_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LINE_REF: ref_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_KP:       kp_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_KI:       ki_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_KD:       kd_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_LIMIT:    limit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // History is written back once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ARRAY_COUNT; k++) begin
        hist_new_q[k] <= '0;
        hist_mid_q[k] <= '0;
        prev_eff_q[k] <= '0;
      end
    end else if (cmd_i.finish) begin
      hist_mid_q[idx_q] <= hist_new_q[idx_q];
      hist_new_q[idx_q] <= e0_q;
      prev_eff_q[idx_q] <= effort_w;
    end
  end

  // Item registers and the shared divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q      <= AW'(idx_m);
      sum_zero_q <= (sum_w == '0);
      lost_q     <= (sum_w < lost_threshold_i);
      rem_q      <= num_w;
      dreg_q     <= {sum_w, 7'b0};
      quo_q      <= '0;
    end else if (cmd_i.gain_load) begin
      sign_q <= gnum_w[11];
      rem_q  <= DIV_W'(gmag_w);
      dreg_q <= {7'b0, gden_w, 10'b0};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dreg_q) begin
        rem_q <= rem_q - dreg_q;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dreg_q <= dreg_q >> 1;
    end
    if (cmd_i.set_err) begin
      e0_q  <= e0_w;
      acc_q <= '0;
    end else if (cmd_i.gain_acc) begin
      acc_q <= acc_q + term_w;
    end
  end

  // Result register; the next item may be taken while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      effort_q <= effort_w;
      perr_q   <= e0_q;
      olost_q  <= lost_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign control_effort_o  = effort_q;
  assign position_error_o  = perr_q;
  assign line_lost_o       = olost_q;

endmodule

/* rtl/line_position_pid.sv */
// Line position PID: one control step per sensor-array update, with a
// controller sequencing a shared datapath. Depends on lpp_pkg and lpp_if.
//
// The single shared restoring divider, which produces one quotient bit per
// cycle, sets the pace: 8 quotient bits for the line position, then 11 for
// each of the three gain terms, plus setup, accumulate and write-back steps.
// One item is worked on at a time; a new item is accepted once the previous
// one has moved into the result register, so a slow result consumer stalls
// the block only after one result is waiting. Configuration writes are always
// accepted and must only be issued while no item is in flight. Array indexes
// wrap modulo ARRAY_COUNT, and a zero divisor register acts as one.
module line_position_pid import lpp_pkg::*; #(
  parameter int unsigned ARRAY_COUNT = LPP_ARRAY_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpp_in_if.sink     in_i,
  lpp_out_if.source  out_o,
  lpp_cfg_if.sink    cfg_i
);

  lpp_cmd_t    cmd;
  lpp_status_t status;
  logic        in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  lpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpp_datapath #(
    .ARRAY_COUNT (ARRAY_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.reg_index),
    .cfg_wdata_i      (cfg_i.wdata),
    .array_index_i    (in_i.array_index),
    .left_period_i    (in_i.left_period),
    .middle_period_i  (in_i.middle_period),
    .right_period_i   (in_i.right_period),
    .lost_threshold_i (in_i.lost_threshold),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .control_effort_o (out_o.control_effort),
    .position_error_o (out_o.position_error),
    .line_lost_o      (out_o.line_lost)
  );

endmodule
